>>> hdl/aslt_pkg.sv
// Shared types, constants and the arctangent table for the angular sector lock table.
// Used by the core, the CORDIC and the sector controller; depends on nothing else.
`default_nettype none

package aslt_pkg;

  localparam int SLOT_COUNT_DEF = 6;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int FORCE_W = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = 4;
  localparam int XY_W = 36;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_CHECK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SEC_MERGE = 2'd0,
    SEC_PROBE = 2'd1,
    SEC_CLEAR = 2'd2
  } sec_op_t;

  typedef struct packed {
    logic    go;
    sec_op_t op;
  } sec_cmd_t;

  typedef struct packed {
    logic done;
    logic blocked;
  } sec_stat_t;

  // Arctangent of 2^-i in units of 2^-32 turns, truncated.
  function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [31:0] val;
    case (idx)
      4'd0:    val = 32'h20000000;
      4'd1:    val = 32'h12E4051E;
      4'd2:    val = 32'h09FB385B;
      4'd3:    val = 32'h051111D4;
      4'd4:    val = 32'h028B0D43;
      4'd5:    val = 32'h0145D7E1;
      4'd6:    val = 32'h00A2F61E;
      4'd7:    val = 32'h00517C55;
      4'd8:    val = 32'h0028BE53;
      4'd9:    val = 32'h00145F2F;
      4'd10:   val = 32'h000A2F98;
      4'd11:   val = 32'h000517CC;
      4'd12:   val = 32'h00028BE6;
      4'd13:   val = 32'h000145F3;
      4'd14:   val = 32'h0000A2F9;
      4'd15:   val = 32'h0000517C;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

>>> hdl/angular_sector_lock_table_core.sv
// Angular sector lock table: stream front end, dispatch and result register.
// Path to output valid: other kinds go direct; an add walks every slot, then places the
// merged sector; a clear empties slots; a check: 16 CORDIC steps, one RAM read per slot.
// One item is in flight at a time; the next input transfer is taken the cycle after
// the result enters the output register, while that result may still wait there.
// Synchronous active-low reset empties every slot; slot contents are not cleared.
`default_nettype none

module angular_sector_lock_table_core #(
  parameter int SLOT_COUNT = aslt_pkg::SLOT_COUNT_DEF,
  parameter int ANGLE_BITS = aslt_pkg::ANGLE_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [95:0] in_tdata,   // start_angle, end_angle, force_x, force_y
  input  wire  [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // force_out_x, force_out_y
  output logic [0:0]  out_tuser   // blocked
);

  import aslt_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE   = 4'b0001,
    T_CORDIC = 4'b0010,
    T_SECT   = 4'b0100,
    T_PUSH   = 4'b1000
  } top_state_t;

  top_state_t                st_r, st_nxt;
  kind_t                     kind_r, kind_nxt;
  logic signed [FORCE_W-1:0] fx_r, fx_nxt;
  logic signed [FORCE_W-1:0] fy_r, fy_nxt;
  logic                      res_blk_r, res_blk_nxt;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [63:0]               out_tdata_r, out_tdata_nxt;
  logic [0:0]                out_tuser_r, out_tuser_nxt;

  logic                      in_xfer;
  kind_t                     in_kind;
  logic signed [FORCE_W-1:0] in_fx, in_fy;
  logic                      cordic_start, cordic_done;
  logic [ANGLE_BITS-1:0]     cordic_angle;
  sec_cmd_t                  sec_cmd;
  sec_stat_t                 sec_stat;
  logic                      pass_force;

  assign in_tready = (st_r == T_IDLE);
  assign in_xfer = in_tvalid && in_tready;
  assign in_kind = kind_t'(in_tuser);
  assign in_fx = in_tdata[63:32];
  assign in_fy = in_tdata[95:64];

  aslt_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .force_x (in_fx),
    .force_y (in_fy),
    .done    (cordic_done),
    .angle   (cordic_angle)
  );

  aslt_sector_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_sector_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (sec_cmd),
    .add_start   (ANGLE_BITS'(in_tdata[15:0])),
    .add_end     (ANGLE_BITS'(in_tdata[31:16])),
    .probe_angle (cordic_angle),
    .stat        (sec_stat)
  );

  always_comb begin
    st_nxt = st_r;
    kind_nxt = kind_r;
    fx_nxt = fx_r;
    fy_nxt = fy_r;
    res_blk_nxt = res_blk_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    cordic_start = 1'b0;
    sec_cmd.go = 1'b0;
    sec_cmd.op = SEC_MERGE;
    pass_force = (kind_r == KIND_CHECK) && !res_blk_r;

    case (st_r)
      T_IDLE: begin
        if (in_xfer) begin
          kind_nxt = in_kind;
          fx_nxt = in_fx;
          fy_nxt = in_fy;
          case (in_kind)
            KIND_ADD: begin
              sec_cmd.go = 1'b1;
              sec_cmd.op = SEC_MERGE;
              st_nxt = T_SECT;
            end
            KIND_CLEAR: begin
              sec_cmd.go = 1'b1;
              sec_cmd.op = SEC_CLEAR;
              st_nxt = T_SECT;
            end
            KIND_CHECK: begin
              cordic_start = 1'b1;
              st_nxt = T_CORDIC;
            end
            default: begin
              res_blk_nxt = 1'b0;
              st_nxt = T_PUSH;
            end
          endcase
        end
      end
      T_CORDIC: begin
        if (cordic_done) begin
          sec_cmd.go = 1'b1;
          sec_cmd.op = SEC_PROBE;
          st_nxt = T_SECT;
        end
      end
      T_SECT: begin
        if (sec_stat.done) begin
          res_blk_nxt = sec_stat.blocked;
          st_nxt = T_PUSH;
        end
      end
      T_PUSH: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt = pass_force ? {fy_r, fx_r} : '0;
          out_tuser_nxt = (kind_r == KIND_CHECK) && res_blk_r;
          st_nxt = T_IDLE;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    kind_r <= kind_nxt;
    fx_r <= fx_nxt;
    fy_r <= fy_nxt;
    res_blk_r <= res_blk_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

  a_sect_done_in_sect: assert property (@(posedge clk) disable iff (!rst_n)
    sec_stat.done |-> st_r == T_SECT)
    else $error("sector controller finished while no table operation was pending");

  a_cordic_done_in_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_done |-> st_r == T_CORDIC)
    else $error("angle unit finished while no check was pending");

  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(st_r == T_PUSH))
    else $error("result appeared without passing through the push state");

  a_blocked_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("blocked result carries a nonzero force");

endmodule

`default_nettype wire

>>> hdl/aslt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; holds the sector slots of the lock table.
`default_nettype none

module aslt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire                                   clk,
  input  wire                                   we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                      wdata,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/aslt_cordic.sv
// Iterative vectoring CORDIC that finds the binary angle of a force vector.
// Depends on aslt_pkg for the step count, datapath width and arctangent table.
`default_nettype none

module aslt_cordic #(
  parameter int ANGLE_BITS = aslt_pkg::ANGLE_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  input  wire  signed [aslt_pkg::FORCE_W-1:0] force_x,
  input  wire  signed [aslt_pkg::FORCE_W-1:0] force_y,
  output logic                              done,
  output logic [ANGLE_BITS-1:0]             angle
);

  import aslt_pkg::*;

  localparam logic [31:0] ROUND_BIT = 32'd1 << (31 - ANGLE_BITS);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic signed [XY_W-1:0]  x_r, x_nxt;
  logic signed [XY_W-1:0]  y_r, y_nxt;
  logic [31:0]             acc_r, acc_nxt;
  logic                    zero_r, zero_nxt;
  logic [ANGLE_BITS-1:0]   ang_r, ang_nxt;

  logic signed [XY_W-1:0]  fx_ext, fy_ext;
  logic signed [XY_W-1:0]  dx, dy;
  logic signed [XY_W-1:0]  x_it, y_it;
  logic [31:0]             acc_it, acc_rnd;

  always_comb begin
    fx_ext = XY_W'(force_x);
    fy_ext = XY_W'(force_y);
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    if (!y_r[XY_W-1]) begin
      x_it = x_r + dx;
      y_it = y_r - dy;
      acc_it = acc_r + atan_lut(step_r);
    end else begin
      x_it = x_r - dx;
      y_it = y_r + dy;
      acc_it = acc_r - atan_lut(step_r);
    end
    acc_rnd = acc_it + ROUND_BIT;

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    x_nxt = x_r;
    y_nxt = y_r;
    acc_nxt = acc_r;
    zero_nxt = zero_r;
    ang_nxt = ang_r;

    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      zero_nxt = (force_x == '0) && (force_y == '0);
      if (force_x[FORCE_W-1]) begin
        x_nxt = -fx_ext;
        y_nxt = -fy_ext;
        acc_nxt = 32'h80000000;
      end else begin
        x_nxt = fx_ext;
        y_nxt = fy_ext;
        acc_nxt = '0;
      end
    end else if (busy_r) begin
      x_nxt = x_it;
      y_nxt = y_it;
      acc_nxt = acc_it;
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        ang_nxt = zero_r ? '0 : acc_rnd[31 -: ANGLE_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    acc_r <= acc_nxt;
    zero_r <= zero_nxt;
    ang_r <= ang_nxt;
  end

  assign done = done_r;
  assign angle = ang_r;

endmodule

`default_nettype wire

>>> hdl/aslt_sector_ctrl.sv
// Sector table controller: valid bits, slot RAM, merge walk and blocked probe.
// Depends on aslt_pkg for command and status types and on aslt_ram.
`default_nettype none

module aslt_sector_ctrl #(
  parameter int SLOT_COUNT = aslt_pkg::SLOT_COUNT_DEF,
  parameter int ANGLE_BITS = aslt_pkg::ANGLE_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire aslt_pkg::sec_cmd_t  cmd,
  input  wire  [ANGLE_BITS-1:0]    add_start,
  input  wire  [ANGLE_BITS-1:0]    add_end,
  input  wire  [ANGLE_BITS-1:0]    probe_angle,
  output aslt_pkg::sec_stat_t      stat
);

  import aslt_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int END_W = ANGLE_BITS + 1;
  localparam int RAM_W = ANGLE_BITS + END_W;
  localparam logic [END_W-1:0] FULL_TURN = {1'b1, {ANGLE_BITS{1'b0}}};
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOT_COUNT);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_WALK  = 3'b010,
    C_PLACE = 3'b100
  } ctl_state_t;

  ctl_state_t            st_r, st_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  sec_op_t               op_r, op_nxt;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [SLOT_COUNT-1:0] hit_r, hit_nxt;
  logic [IDX_W-1:0]      first_r, first_nxt;
  logic                  found_r, found_nxt;
  logic [END_W-1:0]      s_r, s_nxt;
  logic [END_W-1:0]      e_r, e_nxt;
  logic [ANGLE_BITS-1:0] ang_r, ang_nxt;
  logic                  blk_r, blk_nxt;
  logic                  done_r, done_nxt;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_raddr;
  logic [RAM_W-1:0]      ram_wdata;
  logic [RAM_W-1:0]      ram_rdata;

  logic [CNT_W-1:0]      prev_cnt;
  logic [IDX_W-1:0]      slot_idx;
  logic [END_W-1:0]      ts_ext, te_raw, te_unw, ang_ext;
  logic [END_W-1:0]      add_s_ext, add_e_ext, e_fix;
  logic                  m_hit, p_blk;
  logic [END_W-1:0]      m_s, m_e;

  aslt_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (first_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    prev_cnt = cnt_r - CNT_W'(1);
    slot_idx = prev_cnt[IDX_W-1:0];
    ts_ext = {1'b0, ram_rdata[RAM_W-1:END_W]};
    te_raw = ram_rdata[END_W-1:0];
    te_unw = (ts_ext > te_raw) ? te_raw + FULL_TURN : te_raw;
    ang_ext = {1'b0, ang_r};
    add_s_ext = {1'b0, add_start};
    add_e_ext = {1'b0, add_end};
    e_fix = (e_r > FULL_TURN) ? e_r - FULL_TURN : e_r;
    ram_wdata = {s_r[ANGLE_BITS-1:0], e_fix};

    m_hit = 1'b0;
    m_s = s_r;
    m_e = e_r;
    if (!valid_r[slot_idx]) begin
      m_hit = 1'b1;
    end else begin
      if (ts_ext < s_r && te_unw > s_r) begin
        m_hit = 1'b1;
        m_s = ts_ext;
      end
      if (te_unw > e_r && ts_ext < e_r) begin
        m_hit = 1'b1;
        m_e = te_unw;
      end
    end

    p_blk = valid_r[slot_idx] &&
            ((ts_ext < ang_ext && ang_ext < te_raw) ||
             (ts_ext > te_raw && (ts_ext < ang_ext || ang_ext < te_raw)));
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    op_nxt = op_r;
    valid_nxt = valid_r;
    hit_nxt = hit_r;
    first_nxt = first_r;
    found_nxt = found_r;
    s_nxt = s_r;
    e_nxt = e_r;
    ang_nxt = ang_r;
    blk_nxt = blk_r;
    done_nxt = 1'b0;
    ram_we = 1'b0;
    ram_raddr = '0;

    case (st_r)
      C_IDLE: begin
        if (cmd.go) begin
          case (cmd.op)
            SEC_MERGE: begin
              s_nxt = add_s_ext;
              e_nxt = (add_start > add_end) ? add_e_ext + FULL_TURN : add_e_ext;
              hit_nxt = '0;
              found_nxt = 1'b0;
              op_nxt = SEC_MERGE;
              cnt_nxt = CNT_W'(1);
              st_nxt = C_WALK;
            end
            SEC_PROBE: begin
              ang_nxt = probe_angle;
              blk_nxt = 1'b0;
              op_nxt = SEC_PROBE;
              cnt_nxt = CNT_W'(1);
              st_nxt = C_WALK;
            end
            default: begin
              valid_nxt = '0;
              blk_nxt = 1'b0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      C_WALK: begin
        ram_raddr = (cnt_r == LAST_CNT) ? '0 : cnt_r[IDX_W-1:0];
        if (op_r == SEC_PROBE) begin
          blk_nxt = blk_r | p_blk;
        end else begin
          s_nxt = m_s;
          e_nxt = m_e;
          if (m_hit) begin
            hit_nxt[slot_idx] = 1'b1;
            if (!found_r) begin
              found_nxt = 1'b1;
              first_nxt = slot_idx;
            end
          end
        end
        if (cnt_r == LAST_CNT) begin
          if (op_r == SEC_PROBE) begin
            done_nxt = 1'b1;
            st_nxt = C_IDLE;
          end else begin
            st_nxt = C_PLACE;
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      C_PLACE: begin
        if (found_r) begin
          ram_we = 1'b1;
          valid_nxt = (valid_r & ~hit_r) | (SLOT_COUNT'(1) << first_r);
        end
        blk_nxt = 1'b0;
        done_nxt = 1'b1;
        st_nxt = C_IDLE;
      end
      default: begin
        st_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
      cnt_r <= '0;
      valid_r <= '0;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      valid_r <= valid_nxt;
      done_r <= done_nxt;
    end
    op_r <= op_nxt;
    hit_r <= hit_nxt;
    first_r <= first_nxt;
    found_r <= found_nxt;
    s_r <= s_nxt;
    e_r <= e_nxt;
    ang_r <= ang_nxt;
    blk_r <= blk_nxt;
  end

  assign stat.done = done_r;
  assign stat.blocked = blk_r;

endmodule

`default_nettype wire
